>>> src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, switched off while reset is asserted
`define BCI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define BCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCI_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/bci_pkg.sv
`default_nettype none

package bci_pkg;

    localparam int MAX_NODES_DEF = 1024;

    // field widths
    localparam int CMD_W    = 2;
    localparam int TBL_W    = 2;
    localparam int PIDX_W   = 10;
    localparam int RIDX_W   = 11;
    localparam int VAL_W    = 11;
    localparam int RCNT_W   = 11;
    localparam int CCNT_W   = 10;
    // stored parent word: has-parent bit on top of the parent index
    localparam int PARENT_W = PIDX_W + 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_APPEND = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_BUILD  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(3);

    localparam logic [TBL_W-1:0] TBL_ROOTS    = TBL_W'(0);
    localparam logic [TBL_W-1:0] TBL_OFFSETS  = TBL_W'(1);
    localparam logic [TBL_W-1:0] TBL_CHILDREN = TBL_W'(2);

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_BUILD,
        TS_RESULT
    } t_top_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ZERO,
        PH_COUNT,
        PH_PREFIX,
        PH_TAIL,
        PH_SCATTER,
        PH_FINISH
    } t_phase;

    typedef struct packed {
        logic parent_re;
        logic root_we;
        logic off_we;
        logic child_we;
        logic done;
    } t_build_ctl;

endpackage

`default_nettype wire

>>> src/bci_ram.sv
`default_nettype none

module bci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/bci_build.sv
`default_nettype none

`include "assert_macros.svh"

module bci_build #(
    parameter int MAX_NODES = bci_pkg::MAX_NODES_DEF,
    localparam int IW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [CW-1:0]                 i_node_count,
    output logic      [IW-1:0]                 o_parent_addr,
    input  wire logic [bci_pkg::PARENT_W-1:0]  i_parent_data,
    output bci_pkg::t_build_ctl                o_ctl,
    output logic      [IW-1:0]                 o_root_addr,
    output logic      [IW-1:0]                 o_root_data,
    output logic      [CW-1:0]                 o_off_addr,
    output logic      [CW-1:0]                 o_off_data,
    output logic      [IW-1:0]                 o_child_addr,
    output logic      [IW-1:0]                 o_child_data,
    output logic      [CW-1:0]                 o_roots,
    output logic      [CW-1:0]                 o_children,
    output logic                               o_bad
);

    localparam int CMPW = (CW > bci_pkg::PIDX_W) ? CW : bci_pkg::PIDX_W;

    bci_pkg::t_phase r_phase, n_phase;

    logic [CW-1:0] r_idx, n_idx;
    logic          r_s1_valid, n_s1_valid;
    logic [IW-1:0] r_s1_idx, n_s1_idx;
    logic          r_s2_valid, n_s2_valid;
    logic [IW-1:0] r_s2_addr, n_s2_addr;
    logic [IW-1:0] r_s2_idx, n_s2_idx;
    logic          r_wb_valid, n_wb_valid;
    logic [IW-1:0] r_wb_addr, n_wb_addr;
    logic [CW-1:0] r_wb_data, n_wb_data;
    logic [CW-1:0] r_root_ptr, n_root_ptr;
    logic [CW-1:0] r_sum, n_sum;
    logic          r_bad, n_bad;

    logic          cur_we;
    logic [IW-1:0] cur_waddr;
    logic [CW-1:0] cur_wdata;
    logic          cur_re;
    logic [IW-1:0] cur_raddr;
    logic [CW-1:0] cur_rdata;

    logic                      issue_done;
    logic                      pipe_empty;
    logic                      p_has;
    logic [bci_pkg::PIDX_W-1:0] p_idx;
    logic                      p_ok;
    logic [CW-1:0]             cur_fwd;

    // counts in the counting pass, then running cursors in the scatter pass
    bci_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_NODES)
    ) u_cursor_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_re    (cur_re),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    assign issue_done = (r_idx == i_node_count);
    assign pipe_empty = !r_s1_valid && !r_s2_valid;
    assign p_has      = i_parent_data[bci_pkg::PARENT_W-1];
    assign p_idx      = i_parent_data[bci_pkg::PIDX_W-1:0];
    assign p_ok       = CMPW'(p_idx) < CMPW'(i_node_count);
    // the read issued in the cycle before misses the update written in that cycle
    assign cur_fwd    = (r_wb_valid && (r_wb_addr == r_s2_addr)) ? r_wb_data : cur_rdata;

    assign o_parent_addr = r_idx[IW-1:0];
    assign o_roots       = r_root_ptr;
    assign o_children    = r_sum;
    assign o_bad         = r_bad;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            bci_pkg::PH_IDLE: begin
                if (i_start) begin
                    n_phase = bci_pkg::PH_ZERO;
                end
            end
            bci_pkg::PH_ZERO: begin
                if (issue_done) begin
                    n_phase = bci_pkg::PH_COUNT;
                end
            end
            bci_pkg::PH_COUNT: begin
                if (issue_done && pipe_empty) begin
                    n_phase = bci_pkg::PH_PREFIX;
                end
            end
            bci_pkg::PH_PREFIX: begin
                if (issue_done && !r_s1_valid) begin
                    n_phase = bci_pkg::PH_TAIL;
                end
            end
            bci_pkg::PH_TAIL: begin
                n_phase = bci_pkg::PH_SCATTER;
            end
            bci_pkg::PH_SCATTER: begin
                if (issue_done && pipe_empty) begin
                    n_phase = bci_pkg::PH_FINISH;
                end
            end
            bci_pkg::PH_FINISH: begin
                n_phase = bci_pkg::PH_IDLE;
            end
            default: begin
                n_phase = bci_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx        = r_idx;
        n_s1_valid   = 1'b0;
        n_s1_idx     = r_idx[IW-1:0];
        n_s2_valid   = 1'b0;
        n_s2_addr    = IW'(p_idx);
        n_s2_idx     = r_s1_idx;
        n_wb_valid   = 1'b0;
        n_wb_addr    = r_s2_addr;
        n_wb_data    = cur_fwd + CW'(1);
        n_root_ptr   = r_root_ptr;
        n_sum        = r_sum;
        n_bad        = r_bad;
        cur_we       = 1'b0;
        cur_waddr    = r_s2_addr;
        cur_wdata    = cur_fwd + CW'(1);
        cur_re       = 1'b0;
        cur_raddr    = IW'(p_idx);
        o_ctl        = '0;
        o_root_addr  = r_root_ptr[IW-1:0];
        o_root_data  = r_s1_idx;
        o_off_addr   = CW'(r_s1_idx);
        o_off_data   = r_sum;
        o_child_addr = cur_fwd[IW-1:0];
        o_child_data = r_s2_idx;
        case (r_phase)
            bci_pkg::PH_IDLE: begin
                if (i_start) begin
                    n_idx      = '0;
                    n_root_ptr = '0;
                    n_sum      = '0;
                    n_bad      = 1'b0;
                end
            end
            bci_pkg::PH_ZERO: begin
                if (!issue_done) begin
                    cur_we    = 1'b1;
                    cur_waddr = r_idx[IW-1:0];
                    cur_wdata = '0;
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_idx = '0;
                end
            end
            bci_pkg::PH_COUNT, bci_pkg::PH_SCATTER: begin
                if (!issue_done) begin
                    o_ctl.parent_re = 1'b1;
                    n_s1_valid      = 1'b1;
                    n_idx           = r_idx + CW'(1);
                end
                if (r_s1_valid && p_has && p_ok) begin
                    cur_re     = 1'b1;
                    n_s2_valid = 1'b1;
                end
                if (r_phase == bci_pkg::PH_COUNT && r_s1_valid && !p_has) begin
                    o_ctl.root_we = 1'b1;
                    n_root_ptr    = r_root_ptr + CW'(1);
                end
                if (r_phase == bci_pkg::PH_COUNT && r_s1_valid && p_has && !p_ok) begin
                    n_bad = 1'b1;
                end
                if (r_s2_valid) begin
                    cur_we     = 1'b1;
                    n_wb_valid = 1'b1;
                    if (r_phase == bci_pkg::PH_SCATTER) begin
                        o_ctl.child_we = 1'b1;
                    end
                end
                if (issue_done && pipe_empty) begin
                    n_idx = '0;
                end
            end
            bci_pkg::PH_PREFIX: begin
                if (!issue_done) begin
                    cur_re     = 1'b1;
                    cur_raddr  = r_idx[IW-1:0];
                    n_s1_valid = 1'b1;
                    n_idx      = r_idx + CW'(1);
                end
                // count in, exclusive offset out
                if (r_s1_valid) begin
                    o_ctl.off_we = 1'b1;
                    cur_we       = 1'b1;
                    cur_waddr    = r_s1_idx;
                    cur_wdata    = r_sum;
                    n_sum        = r_sum + cur_rdata;
                end
            end
            bci_pkg::PH_TAIL: begin
                n_idx = '0;
                // closing total, only when the offsets list is not empty
                if (i_node_count != '0) begin
                    o_ctl.off_we = 1'b1;
                    o_off_addr   = i_node_count;
                end
            end
            bci_pkg::PH_FINISH: begin
                o_ctl.done = 1'b1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bci_pkg::PH_IDLE;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
            r_wb_valid <= n_wb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx   <= n_s1_idx;
        r_s2_addr  <= n_s2_addr;
        r_s2_idx   <= n_s2_idx;
        r_wb_addr  <= n_wb_addr;
        r_wb_data  <= n_wb_data;
        r_root_ptr <= n_root_ptr;
        r_sum      <= n_sum;
        r_bad      <= n_bad;
    end

    `BCI_ASSERT(a_s2_in_pass, i_clk, i_rst_n, r_s2_valid |-> (r_phase == bci_pkg::PH_COUNT || r_phase == bci_pkg::PH_SCATTER), "cursor update outside counting or scatter pass")
    `BCI_ASSERT(a_fwd_source, i_clk, i_rst_n, r_wb_valid |-> $past(r_s2_valid), "forward entry without a preceding update")
    `BCI_ASSERT(a_done_pulse, i_clk, i_rst_n, o_ctl.done |=> !o_ctl.done, "build done held longer than one cycle")
    `BCI_ASSERT(a_roots_bound, i_clk, i_rst_n, (r_phase != bci_pkg::PH_IDLE && r_phase != bci_pkg::PH_ZERO) |-> (r_root_ptr <= i_node_count), "more roots than nodes")

endmodule

`default_nettype wire

>>> src/build_child_index.sv
`default_nettype none

`include "assert_macros.svh"

// channel  direction  handshake                   beat
// in       input      i_in_valid / o_in_ready     command, parent link, read request
// out      output     o_out_valid / i_out_ready   value, in_range, counts, flags
//
// clear and append give no beat; a read is answered from the registered list memory,
// its data held until the output register is free, and reads can follow back to back
// while the output does not stall. build holds the input for N stored nodes through a
// zeroing sweep, then counting, prefix and scatter sweeps over the cursor memory, one
// node a cycle, the last three each with a short pipeline drain.
// reset clears the node count, list lengths and flags; no memory sweep.
// input stalls while a build runs or its beat waits, or while a read beat waits on a
// stalled output.

module build_child_index #(
    parameter int MAX_NODES = bci_pkg::MAX_NODES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [bci_pkg::CMD_W-1:0]    i_command,
    input  wire logic                         i_has_parent,
    input  wire logic [bci_pkg::PIDX_W-1:0]   i_parent_index,
    input  wire logic [bci_pkg::TBL_W-1:0]    i_read_table,
    input  wire logic [bci_pkg::RIDX_W-1:0]   i_read_index,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [bci_pkg::VAL_W-1:0]    o_value,
    output logic                              o_in_range,
    output logic      [bci_pkg::RCNT_W-1:0]   o_root_count,
    output logic      [bci_pkg::CCNT_W-1:0]   o_child_count,
    output logic                              o_bad_parent,
    output logic                              o_overflow
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int XW = (CW > bci_pkg::RIDX_W) ? CW : bci_pkg::RIDX_W;
    localparam int VW = bci_pkg::VAL_W;
    localparam int RW = bci_pkg::RCNT_W;
    localparam int HW = bci_pkg::CCNT_W;

    bci_pkg::t_top_state r_state, n_state;

    logic [CW-1:0] r_node_count;
    logic [CW-1:0] r_built_n;
    logic [CW-1:0] r_roots;
    logic [CW-1:0] r_children;
    logic          r_bad;
    logic          r_ovf;

    logic                      r_rd_pend;
    logic [bci_pkg::TBL_W-1:0] r_rd_tbl;
    logic                      r_rd_ok;

    logic          r_out_valid;
    logic [VW-1:0] r_o_value;
    logic          r_o_in_range;
    logic [RW-1:0] r_o_root_count;
    logic [HW-1:0] r_o_child_count;
    logic          r_o_bad;
    logic          r_o_ovf;

    logic          in_acc;
    logic          rd_acc;
    logic          out_free;
    logic          load_rd;
    logic          load_build;
    logic          bld_start;
    logic          full;
    logic [XW-1:0] idx_x;
    logic          rd_ok;
    logic [VW-1:0] rd_value;

    logic [IW-1:0]                 parent_raddr;
    logic [bci_pkg::PARENT_W-1:0]  parent_rdata;
    bci_pkg::t_build_ctl           bld_ctl;
    logic [IW-1:0]                 root_waddr;
    logic [IW-1:0]                 root_wdata;
    logic [IW-1:0]                 root_rdata;
    logic [CW-1:0]                 off_waddr;
    logic [CW-1:0]                 off_wdata;
    logic [CW-1:0]                 off_rdata;
    logic [IW-1:0]                 child_waddr;
    logic [IW-1:0]                 child_wdata;
    logic [IW-1:0]                 child_rdata;
    logic [CW-1:0]                 bld_roots;
    logic [CW-1:0]                 bld_children;
    logic                          bld_bad;

    assign in_acc   = i_in_valid && o_in_ready;
    assign rd_acc   = in_acc && (i_command == bci_pkg::CMD_READ);
    assign out_free = !r_out_valid || i_out_ready;
    assign load_rd  = r_rd_pend && out_free;
    assign full     = (r_node_count == CW'(MAX_NODES));
    assign idx_x    = XW'(i_read_index);

    bci_ram #(
        .WIDTH (bci_pkg::PARENT_W),
        .DEPTH (MAX_NODES)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_command == bci_pkg::CMD_APPEND) && !full),
        .i_waddr (r_node_count[IW-1:0]),
        .i_wdata ({i_has_parent, i_parent_index}),
        .i_re    (bld_ctl.parent_re),
        .i_raddr (parent_raddr),
        .o_rdata (parent_rdata)
    );

    bci_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_NODES)
    ) u_root_ram (
        .i_clk   (i_clk),
        .i_we    (bld_ctl.root_we),
        .i_waddr (root_waddr),
        .i_wdata (root_wdata),
        .i_re    (rd_acc),
        .i_raddr (idx_x[IW-1:0]),
        .o_rdata (root_rdata)
    );

    bci_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_NODES + 1)
    ) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (bld_ctl.off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_re    (rd_acc),
        .i_raddr (idx_x[CW-1:0]),
        .o_rdata (off_rdata)
    );

    bci_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_NODES)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (bld_ctl.child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_re    (rd_acc),
        .i_raddr (idx_x[IW-1:0]),
        .o_rdata (child_rdata)
    );

    bci_build #(
        .MAX_NODES (MAX_NODES)
    ) u_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (bld_start),
        .i_node_count  (r_node_count),
        .o_parent_addr (parent_raddr),
        .i_parent_data (parent_rdata),
        .o_ctl         (bld_ctl),
        .o_root_addr   (root_waddr),
        .o_root_data   (root_wdata),
        .o_off_addr    (off_waddr),
        .o_off_data    (off_wdata),
        .o_child_addr  (child_waddr),
        .o_child_data  (child_wdata),
        .o_roots       (bld_roots),
        .o_children    (bld_children),
        .o_bad         (bld_bad)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            bci_pkg::TS_IDLE: begin
                if (in_acc && i_command == bci_pkg::CMD_BUILD) begin
                    n_state = bci_pkg::TS_BUILD;
                end
            end
            bci_pkg::TS_BUILD: begin
                if (bld_ctl.done) begin
                    n_state = bci_pkg::TS_RESULT;
                end
            end
            bci_pkg::TS_RESULT: begin
                if (out_free) begin
                    n_state = bci_pkg::TS_IDLE;
                end
            end
            default: begin
                n_state = bci_pkg::TS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == bci_pkg::TS_IDLE) && (!r_rd_pend || out_free);
        bld_start  = in_acc && (i_command == bci_pkg::CMD_BUILD);
        load_build = (r_state == bci_pkg::TS_RESULT) && out_free;
    end

    // range check against the list lengths of the last build
    always_comb begin
        case (i_read_table)
            bci_pkg::TBL_ROOTS:    rd_ok = idx_x < XW'(r_roots);
            bci_pkg::TBL_OFFSETS:  rd_ok = (r_built_n != '0) && (idx_x <= XW'(r_built_n));
            bci_pkg::TBL_CHILDREN: rd_ok = idx_x < XW'(r_children);
            default:               rd_ok = 1'b0;
        endcase
    end

    always_comb begin
        case (r_rd_tbl)
            bci_pkg::TBL_ROOTS:    rd_value = VW'(root_rdata);
            bci_pkg::TBL_OFFSETS:  rd_value = VW'(off_rdata);
            bci_pkg::TBL_CHILDREN: rd_value = VW'(child_rdata);
            default:               rd_value = '0;
        endcase
        if (!r_rd_ok) begin
            rd_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bci_pkg::TS_IDLE;
            r_node_count <= '0;
            r_built_n    <= '0;
            r_roots      <= '0;
            r_children   <= '0;
            r_bad        <= 1'b0;
            r_ovf        <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (i_command)
                    bci_pkg::CMD_CLEAR: begin
                        r_node_count <= '0;
                        r_built_n    <= '0;
                        r_roots      <= '0;
                        r_children   <= '0;
                        r_bad        <= 1'b0;
                        r_ovf        <= 1'b0;
                    end
                    bci_pkg::CMD_APPEND: begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_node_count <= r_node_count + CW'(1);
                        end
                    end
                    bci_pkg::CMD_BUILD: begin
                        r_built_n <= r_node_count;
                    end
                    default: begin
                        r_built_n <= r_built_n;
                    end
                endcase
            end
            if (bld_ctl.done) begin
                r_roots    <= bld_roots;
                r_children <= bld_children;
                r_bad      <= bld_bad;
            end
            if (rd_acc) begin
                r_rd_pend <= 1'b1;
            end else if (load_rd) begin
                r_rd_pend <= 1'b0;
            end
            if (load_rd || load_build) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_rd_tbl <= i_read_table;
            r_rd_ok  <= rd_ok;
        end
        if (load_rd || load_build) begin
            r_o_root_count  <= RW'(r_roots);
            r_o_child_count <= HW'(r_children);
            r_o_bad         <= r_bad;
            r_o_ovf         <= r_ovf;
        end
        if (load_rd) begin
            r_o_value    <= rd_value;
            r_o_in_range <= r_rd_ok;
        end else if (load_build) begin
            r_o_value    <= '0;
            r_o_in_range <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_o_value;
    assign o_in_range    = r_o_in_range;
    assign o_root_count  = r_o_root_count;
    assign o_child_count = r_o_child_count;
    assign o_bad_parent  = r_o_bad;
    assign o_overflow    = r_o_ovf;

    `BCI_ASSERT(a_single_load, i_clk, i_rst_n, !(r_rd_pend && r_state == bci_pkg::TS_RESULT), "read beat and build beat compete for the output")
    `BCI_ASSERT(a_count_bound, i_clk, i_rst_n, r_node_count <= CW'(MAX_NODES), "node count beyond capacity")
    `BCI_ASSERT(a_ovf_sticky, i_clk, i_rst_n, (r_ovf && !(in_acc && i_command == bci_pkg::CMD_CLEAR)) |=> r_ovf, "overflow flag dropped without a clear")
    `BCI_ASSERT(a_no_take_in_build, i_clk, i_rst_n, (r_state == bci_pkg::TS_BUILD) |-> !o_in_ready, "input taken while a build runs")

endmodule

`default_nettype wire
